>>> design/thc_pkg.sv
// Shared constants, types and the arctangent table for the heading pipeline.
package thc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN = 24;
    localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    localparam int RW = 33;
    localparam int ZW = 23;
    localparam int QW = 22;
    localparam int PW = 44;
    localparam int MW = 38;
    localparam int VW = 61;
    localparam int AW = 26;

    localparam logic signed [RW-1:0] INV_GAIN = RW'(652032874);
    localparam logic signed [AW-1:0] FULL_TURN = AW'(5898240);
    localparam logic signed [AW-1:0] HALF_TURN = AW'(2949120);
    localparam logic signed [15:0] HALF_64 = 16'sd11520;
    localparam logic signed [15:0] FULL_64 = 16'sd23040;
    localparam logic signed [15:0] QUARTER_64 = 16'sd5760;
    localparam logic signed [14:0] DECL_RESET = -15'sd411;
    localparam logic [12:0] LIMIT_RESET = 13'd2860;

    localparam logic [1:0] REG_DECL = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;

    typedef struct packed {
        logic               tilt;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } side_t;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(737280);
            1:  v = ZW'(435242);
            2:  v = ZW'(229970);
            3:  v = ZW'(116736);
            4:  v = ZW'(58595);
            5:  v = ZW'(29326);
            6:  v = ZW'(14667);
            7:  v = ZW'(7334);
            8:  v = ZW'(3667);
            9:  v = ZW'(1833);
            10: v = ZW'(917);
            11: v = ZW'(458);
            12: v = ZW'(229);
            13: v = ZW'(115);
            14: v = ZW'(57);
            15: v = ZW'(29);
            16: v = ZW'(14);
            17: v = ZW'(7);
            18: v = ZW'(4);
            19: v = ZW'(2);
            20: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/thc_rot_cordic.sv
// Pipelined rotation CORDIC giving cosine and sine of pitch and roll in Q20.
module thc_rot_cordic (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [thc_pkg::ZW-1:0]   in_z_pitch,
    input  logic signed [thc_pkg::ZW-1:0]   in_z_roll,
    input  logic                            in_neg_pitch,
    input  logic                            in_neg_roll,
    input  thc_pkg::side_t                  in_side,
    output logic                            out_valid,
    output logic signed [thc_pkg::QW-1:0]   out_cp,
    output logic signed [thc_pkg::QW-1:0]   out_sp,
    output logic signed [thc_pkg::QW-1:0]   out_cr,
    output logic signed [thc_pkg::QW-1:0]   out_sr,
    output thc_pkg::side_t                  out_side
);

    localparam int N = thc_pkg::NSTEP;
    localparam int RW = thc_pkg::RW;
    localparam int ZW = thc_pkg::ZW;
    localparam int QW = thc_pkg::QW;

    logic signed [RW-1:0] x_reg [2][N+1];
    logic signed [RW-1:0] y_reg [2][N+1];
    logic signed [ZW-1:0] z_reg [2][N+1];
    logic                 neg_reg [2][N+1];
    thc_pkg::side_t       side_reg [N+1];
    logic                 v_reg [N+2];

    logic signed [QW-1:0] cos_reg [2];
    logic signed [QW-1:0] sin_reg [2];
    thc_pkg::side_t       side_out_reg;

    logic signed [RW-1:0] xr [2];
    logic signed [RW-1:0] yr [2];
    logic signed [QW-1:0] cos_next [2];
    logic signed [QW-1:0] sin_next [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N + 2; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < N + 2; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0][0] <= thc_pkg::INV_GAIN;
            x_reg[1][0] <= thc_pkg::INV_GAIN;
            y_reg[0][0] <= '0;
            y_reg[1][0] <= '0;
            z_reg[0][0] <= in_z_pitch;
            z_reg[1][0] <= in_z_roll;
            neg_reg[0][0] <= in_neg_pitch;
            neg_reg[1][0] <= in_neg_roll;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_iter
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (z_reg[l][k-1] >= 0)
                    begin
                        x_reg[l][k] <= x_reg[l][k-1] - (y_reg[l][k-1] >>> (k - 1));
                        y_reg[l][k] <= y_reg[l][k-1] + (x_reg[l][k-1] >>> (k - 1));
                        z_reg[l][k] <= z_reg[l][k-1] - thc_pkg::atan_val(k - 1);
                    end
                    else
                    begin
                        x_reg[l][k] <= x_reg[l][k-1] + (y_reg[l][k-1] >>> (k - 1));
                        y_reg[l][k] <= y_reg[l][k-1] - (x_reg[l][k-1] >>> (k - 1));
                        z_reg[l][k] <= z_reg[l][k-1] + thc_pkg::atan_val(k - 1);
                    end
                    neg_reg[l][k] <= neg_reg[l][k-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Q30 to Q20 with round half up, then undo the half-turn fold
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            xr[l] = (x_reg[l][N] + RW'(512)) >>> 10;
            yr[l] = (y_reg[l][N] + RW'(512)) >>> 10;
            cos_next[l] = neg_reg[l][N] ? -xr[l][QW-1:0] : xr[l][QW-1:0];
            sin_next[l] = neg_reg[l][N] ? -yr[l][QW-1:0] : yr[l][QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < 2; l++)
            begin
                cos_reg[l] <= cos_next[l];
                sin_reg[l] <= sin_next[l];
            end
            side_out_reg <= side_reg[N];
        end
    end

    assign out_valid = v_reg[N+1];
    assign out_cp = cos_reg[0];
    assign out_sp = sin_reg[0];
    assign out_cr = cos_reg[1];
    assign out_sr = sin_reg[1];
    assign out_side = side_out_reg;

endmodule

>>> design/thc_tilt_mix.sv
// Two-stage multiplier array forming the horizontal field components.
module thc_tilt_mix (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [thc_pkg::QW-1:0]   in_cp,
    input  logic signed [thc_pkg::QW-1:0]   in_sp,
    input  logic signed [thc_pkg::QW-1:0]   in_cr,
    input  logic signed [thc_pkg::QW-1:0]   in_sr,
    input  thc_pkg::side_t                  in_side,
    output logic                            out_valid,
    output logic signed [thc_pkg::VW-1:0]   out_vx,
    output logic signed [thc_pkg::VW-1:0]   out_vy,
    output logic                            out_tilt
);

    localparam int PW = thc_pkg::PW;
    localparam int MW = thc_pkg::MW;
    localparam int VW = thc_pkg::VW;

    logic                 v1_reg;
    logic                 v2_reg;
    logic signed [PW-1:0] spsr_reg;
    logic signed [PW-1:0] cpsr_reg;
    logic signed [MW-1:0] mycp_reg;
    logic signed [MW-1:0] mzsp_reg;
    logic signed [MW-1:0] mxcr_reg;
    thc_pkg::side_t       side_reg;
    logic signed [VW-1:0] vx_reg;
    logic signed [VW-1:0] vy_reg;
    logic                 tilt_reg;

    logic signed [VW-1:0] t_my;
    logic signed [VW-1:0] t_mz;
    logic signed [MW-1:0] d_x;
    logic signed [VW-1:0] vx_next;
    logic signed [VW-1:0] vy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            spsr_reg <= in_sp * in_sr;
            cpsr_reg <= in_cp * in_sr;
            mycp_reg <= in_side.my * in_cp;
            mzsp_reg <= in_side.mz * in_sp;
            mxcr_reg <= in_side.mx * in_cr;
            side_reg <= in_side;
        end
    end

    always_comb
    begin
        t_my = side_reg.my * spsr_reg;
        t_mz = side_reg.mz * cpsr_reg;
        d_x = mycp_reg - mzsp_reg;
        if (side_reg.tilt)
        begin
            vy_next = (VW'(mxcr_reg) <<< 20) + t_my - t_mz;
            vx_next = VW'(d_x) <<< 20;
        end
        else
        begin
            vy_next = VW'(side_reg.mx) <<< 40;
            vx_next = VW'(side_reg.my) <<< 40;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            tilt_reg <= side_reg.tilt;
        end
    end

    assign out_valid = v2_reg;
    assign out_vx = vx_reg;
    assign out_vy = vy_reg;
    assign out_tilt = tilt_reg;

endmodule

>>> design/thc_vec_cordic.sv
// Pipelined vectoring CORDIC with declination offset, wrap and rounding.
module thc_vec_cordic (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [thc_pkg::VW-1:0]   in_vx,
    input  logic signed [thc_pkg::VW-1:0]   in_vy,
    input  logic                            in_tilt,
    input  logic signed [14:0]              decl,
    output logic                            out_valid,
    output logic [14:0]                     out_heading,
    output logic                            out_tilt
);

    localparam int N = thc_pkg::NSTEP;
    localparam int VW = thc_pkg::VW;
    localparam int AW = thc_pkg::AW;

    logic signed [VW-1:0] x_reg [N+1];
    logic signed [VW-1:0] y_reg [N+1];
    logic signed [AW-1:0] z_reg [N+1];
    logic signed [AW-1:0] base_reg [N+1];
    logic                 zero_reg [N+1];
    logic                 tilt_reg [N+1];
    logic                 v_reg [N+3];

    logic signed [AW-1:0] h_reg;
    logic                 tilt_h_reg;
    logic [14:0]          heading_reg;
    logic                 tilt_out_reg;

    logic signed [AW-1:0] base_next;
    logic signed [AW-1:0] z_sum;
    logic signed [AW-1:0] z_wrap;
    logic signed [AW-1:0] h_next;
    logic signed [AW-1:0] h_a;
    logic signed [AW-1:0] h_b;
    logic signed [AW-1:0] h_c;
    logic signed [AW-1:0] h_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N + 3; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < N + 3; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // left half-plane: mirror the vector and start from a half turn
    always_comb
    begin
        if (in_vx < 0)
        begin
            base_next = (in_vy >= 0) ? thc_pkg::HALF_TURN : -thc_pkg::HALF_TURN;
        end
        else
        begin
            base_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0] <= (in_vx < 0) ? -in_vx : in_vx;
            y_reg[0] <= (in_vx < 0) ? -in_vy : in_vy;
            z_reg[0] <= '0;
            base_reg[0] <= base_next;
            zero_reg[0] <= (in_vx == '0) && (in_vy == '0);
            tilt_reg[0] <= in_tilt;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (y_reg[k-1] > 0)
                begin
                    x_reg[k] <= x_reg[k-1] + (y_reg[k-1] >>> (k - 1));
                    y_reg[k] <= y_reg[k-1] - (x_reg[k-1] >>> (k - 1));
                    z_reg[k] <= z_reg[k-1] + AW'(thc_pkg::atan_val(k - 1));
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] - (y_reg[k-1] >>> (k - 1));
                    y_reg[k] <= y_reg[k-1] + (x_reg[k-1] >>> (k - 1));
                    z_reg[k] <= z_reg[k-1] - AW'(thc_pkg::atan_val(k - 1));
                end
                base_reg[k] <= base_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                tilt_reg[k] <= tilt_reg[k-1];
            end
        end
    end

    always_comb
    begin
        z_sum = z_reg[N] + base_reg[N];
        if (z_sum > thc_pkg::HALF_TURN)
        begin
            z_wrap = z_sum - thc_pkg::FULL_TURN;
        end
        else if (z_sum <= -thc_pkg::HALF_TURN)
        begin
            z_wrap = z_sum + thc_pkg::FULL_TURN;
        end
        else
        begin
            z_wrap = z_sum;
        end
        if (zero_reg[N])
        begin
            z_wrap = '0;
        end
        h_next = z_wrap + (AW'(decl) <<< 8);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            h_reg <= h_next;
            tilt_h_reg <= tilt_reg[N];
        end
    end

    // at most two turns below zero, one above
    always_comb
    begin
        h_a = (h_reg < 0) ? h_reg + thc_pkg::FULL_TURN : h_reg;
        h_b = (h_a < 0) ? h_a + thc_pkg::FULL_TURN : h_a;
        h_c = (h_b > thc_pkg::FULL_TURN) ? h_b - thc_pkg::FULL_TURN : h_b;
        h_r = h_c + AW'(128);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            heading_reg <= h_r[22:8];
            tilt_out_reg <= tilt_h_reg;
        end
    end

    assign out_valid = v_reg[N+2];
    assign out_heading = heading_reg;
    assign out_tilt = tilt_out_reg;

endmodule

>>> design/tilt_compensated_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata: mag_x, mag_y, mag_z, pitch, roll; tuser: kind
// m_axis    out  m_axis_tvalid/tready   tdata: heading; tuser: tilt_applied
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not held; the stages
// are angle prep, rotation CORDIC, two multiplier stages, vectoring CORDIC, wrap.
// All stages share one enable: a held output stalls the whole pipe, nothing
// is dropped or repeated. Reset clears valid bits and loads config defaults.
// cfg_ready is always high.
module tilt_compensated_heading (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // mag_x, mag_y, mag_z, pitch, roll, zero pad
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // heading, zero pad
    output logic        m_axis_tuser,   // tilt_applied
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ZW = thc_pkg::ZW;
    localparam int QW = thc_pkg::QW;
    localparam int VW = thc_pkg::VW;

    logic               ce;
    logic signed [14:0] decl_reg;
    logic [12:0]        limit_reg;

    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic signed [15:0] p_in;
    logic signed [15:0] r_in;
    logic [15:0]        ap;
    logic [15:0]        ar;
    logic signed [15:0] p_a;
    logic signed [15:0] r_a;
    logic signed [15:0] p_f;
    logic signed [15:0] r_f;
    logic               p_neg;
    logic               r_neg;
    thc_pkg::side_t     side_next;

    logic               s0_v_reg;
    logic signed [ZW-1:0] zp_reg;
    logic signed [ZW-1:0] zr_reg;
    logic               np_reg;
    logic               nr_reg;
    thc_pkg::side_t     side_reg;

    logic               rot_v;
    logic signed [QW-1:0] cp;
    logic signed [QW-1:0] sp;
    logic signed [QW-1:0] cr;
    logic signed [QW-1:0] sr;
    thc_pkg::side_t     rot_side;

    logic               mix_v;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic               mix_tilt;

    logic [14:0]        heading;

    assign ce = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= thc_pkg::DECL_RESET;
            limit_reg <= thc_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                thc_pkg::REG_DECL:  decl_reg <= cfg_data[14:0];
                thc_pkg::REG_LIMIT: limit_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mx = s_axis_tdata[15:0];
        my = s_axis_tdata[31:16];
        mz = s_axis_tdata[47:32];
        p_in = 16'(signed'(s_axis_tdata[62:48]));
        r_in = 16'(signed'(s_axis_tdata[77:63]));
        ap = (p_in < 0) ? 16'(-p_in) : 16'(p_in);
        ar = (r_in < 0) ? 16'(-r_in) : 16'(r_in);

        if (p_in > thc_pkg::HALF_64)
            p_a = p_in - thc_pkg::FULL_64;
        else if (p_in <= -thc_pkg::HALF_64)
            p_a = p_in + thc_pkg::FULL_64;
        else
            p_a = p_in;
        if (r_in > thc_pkg::HALF_64)
            r_a = r_in - thc_pkg::FULL_64;
        else if (r_in <= -thc_pkg::HALF_64)
            r_a = r_in + thc_pkg::FULL_64;
        else
            r_a = r_in;

        // fold into +-90 degrees, sign of cos and sin flips
        p_neg = 1'b1;
        if (p_a > thc_pkg::QUARTER_64)
            p_f = p_a - thc_pkg::HALF_64;
        else if (p_a < -thc_pkg::QUARTER_64)
            p_f = p_a + thc_pkg::HALF_64;
        else
        begin
            p_f = p_a;
            p_neg = 1'b0;
        end
        r_neg = 1'b1;
        if (r_a > thc_pkg::QUARTER_64)
            r_f = r_a - thc_pkg::HALF_64;
        else if (r_a < -thc_pkg::QUARTER_64)
            r_f = r_a + thc_pkg::HALF_64;
        else
        begin
            r_f = r_a;
            r_neg = 1'b0;
        end

        side_next.tilt = s_axis_tuser && (ap <= 16'(limit_reg)) && (ar <= 16'(limit_reg));
        side_next.mx = mx;
        side_next.my = my;
        side_next.mz = mz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (ce)
            s0_v_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            zp_reg <= ZW'(p_f) <<< 8;
            zr_reg <= ZW'(r_f) <<< 8;
            np_reg <= p_neg;
            nr_reg <= r_neg;
            side_reg <= side_next;
        end
    end

    thc_rot_cordic u_rot (
        .clk          (clk),
        .rst_n        (rst_n),
        .ce           (ce),
        .in_valid     (s0_v_reg),
        .in_z_pitch   (zp_reg),
        .in_z_roll    (zr_reg),
        .in_neg_pitch (np_reg),
        .in_neg_roll  (nr_reg),
        .in_side      (side_reg),
        .out_valid    (rot_v),
        .out_cp       (cp),
        .out_sp       (sp),
        .out_cr       (cr),
        .out_sr       (sr),
        .out_side     (rot_side)
    );

    thc_tilt_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (rot_v),
        .in_cp     (cp),
        .in_sp     (sp),
        .in_cr     (cr),
        .in_sr     (sr),
        .in_side   (rot_side),
        .out_valid (mix_v),
        .out_vx    (vx),
        .out_vy    (vy),
        .out_tilt  (mix_tilt)
    );

    thc_vec_cordic u_vec (
        .clk         (clk),
        .rst_n       (rst_n),
        .ce          (ce),
        .in_valid    (mix_v),
        .in_vx       (vx),
        .in_vy       (vy),
        .in_tilt     (mix_tilt),
        .decl        (decl_reg),
        .out_valid   (m_axis_tvalid),
        .out_heading (heading),
        .out_tilt    (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, heading};

endmodule

>>> design/thc_checker.sv
// Port-level checker for the heading pipeline, bound to the top level.
module thc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_idle_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= 16'd23040))
        else $error("heading beyond full turn");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready not tied to output stall");

endmodule

bind tilt_compensated_heading thc_checker u_thc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
